[src/cdq_pkg.sv]
package cdq_pkg;

  // Fixed field widths of the item interface
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;

  // Operation codes
  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [VAL_W-1:0] push_value;
  } cdq_req_t;

  typedef struct packed {
    logic                    accepted;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] rear_value;
    logic                    empty_flag;
    logic                    full_flag;
    logic [CNT_W-1:0]        entry_count;
  } cdq_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } cdq_state_t;

endpackage

[src/circular_deque_unit.sv]
// circular_deque_unit: double-ended queue held in a ring memory.
//
// Request channel (req_valid / req_stall / req): one item per operation,
// push front, push back, pop front or pop back. Response channel
// (rsp_valid / rsp_stall / rsp): exactly one item per request, giving
// success, front and rear values (-1 when empty), empty, full and count.
// An item moves at a clock edge where valid is high and stall is low.
//
// Pushes and refused operations answer in the cycle after the request is
// taken; a pop that leaves entries first passes through ST_READ, as the new
// front or rear must be fetched through the memory's registered read port.
// One item is in flight at a time: no request is taken while a pop waits
// in ST_READ for that single read port.
//
// cfg_write / cfg_data set the active capacity (0 reads as 1, values above
// MAX_DEPTH saturate) and empty the deque; write only while idle.
// Reset (rst, synchronous) empties the deque and sets capacity to MAX_DEPTH.
// While a valid rsp is stalled the response register holds and no request is taken.
module circular_deque_unit #(
  parameter int MAX_DEPTH  = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  cdq_pkg::cdq_req_t         req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output cdq_pkg::cdq_rsp_t         rsp,
  input  logic                      cfg_write,
  input  logic [cdq_pkg::CNT_W-1:0] cfg_data
);

  import cdq_pkg::*;

  localparam int STORE_W = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic               req_fire;
  logic               busy;
  logic               res_valid;
  cdq_rsp_t           res;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [STORE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_raddr;
  logic [STORE_W-1:0] mem_rdata;

  // take a request only when idle and the response slot is free or draining
  assign req_stall = busy || (rsp_valid && rsp_stall);
  assign req_fire  = req_valid && !req_stall;

  cdq_ctrl #(
    .MAX_DEPTH  (MAX_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req_fire  (req_fire),
    .req       (req),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  cdq_ring_mem #(
    .DEPTH  (MAX_DEPTH),
    .DATA_W (STORE_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      rsp <= res;
    end
  end

endmodule

[src/cdq_ring_mem.sv]
module cdq_ring_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 32,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/cdq_ctrl.sv]
module cdq_ctrl #(
  parameter int MAX_DEPTH  = 1024,
  parameter int VALUE_BITS = 32,
  localparam int STORE_W = (VALUE_BITS < cdq_pkg::VAL_W) ? VALUE_BITS : cdq_pkg::VAL_W,
  localparam int IDX_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [cdq_pkg::CNT_W-1:0] cfg_data,
  input  logic                      req_fire,
  input  cdq_pkg::cdq_req_t         req,
  output logic                      busy,
  output logic                      res_valid,
  output cdq_pkg::cdq_rsp_t         res,
  output logic                      mem_we,
  output logic [IDX_W-1:0]          mem_waddr,
  output logic [STORE_W-1:0]        mem_wdata,
  output logic                      mem_re,
  output logic [IDX_W-1:0]          mem_raddr,
  input  logic [STORE_W-1:0]        mem_rdata
);

  import cdq_pkg::*;

  // capacity and count wide enough to hold MAX_DEPTH itself
  localparam int CAP_W = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(MAX_DEPTH);

  cdq_state_t       state, state_next;
  logic [CAP_W-1:0] cap, cap_next;
  logic [IDX_W-1:0] front_idx, front_idx_next;
  logic [IDX_W-1:0] back_idx, back_idx_next;
  logic [CAP_W-1:0] count, count_next;
  logic [STORE_W-1:0] front_val, front_val_next;
  logic [STORE_W-1:0] rear_val, rear_val_next;
  logic             pop_front, pop_front_next;

  logic             is_full;
  logic             is_empty;
  logic [IDX_W-1:0] back_dn;
  logic             ok;

  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i,
                                                input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] n;
    n = CAP_W'(i) + 1'b1;
    return (n >= c) ? '0 : n[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i,
                                                  input logic [CAP_W-1:0] c);
    return (i == '0) ? IDX_W'(c - 1'b1) : (i - 1'b1);
  endfunction

  function automatic logic signed [VAL_W-1:0] sext(input logic [STORE_W-1:0] v);
    return VAL_W'(signed'(v));
  endfunction

  assign is_full  = (count >= cap);
  assign is_empty = (count == '0);
  assign back_dn  = step_down(back_idx, cap);
  assign busy     = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    cap_next       = cap;
    front_idx_next = front_idx;
    back_idx_next  = back_idx;
    count_next     = count;
    front_val_next = front_val;
    rear_val_next  = rear_val;
    pop_front_next = pop_front;
    ok             = 1'b0;
    res_valid      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = back_idx;
    mem_wdata      = req.push_value[STORE_W-1:0];
    mem_re         = 1'b0;
    mem_raddr      = step_up(front_idx, cap);

    case (state)
      ST_IDLE: begin
        if (cfg_write) begin
          if (cfg_data == '0) begin
            cap_next = CAP_W'(1);
          end else if (CAP_W'(cfg_data) > CAP_MAX) begin
            cap_next = CAP_MAX;
          end else begin
            cap_next = CAP_W'(cfg_data);
          end
          front_idx_next = '0;
          back_idx_next  = '0;
          count_next     = '0;
        end else if (req_fire) begin
          res_valid = 1'b1;
          case (req.op)
            OP_PUSH_FRONT: begin
              if (!is_full) begin
                ok             = 1'b1;
                front_idx_next = step_down(front_idx, cap);
                mem_we         = 1'b1;
                mem_waddr      = front_idx_next;
                count_next     = count + 1'b1;
                front_val_next = mem_wdata;
                if (is_empty) begin
                  rear_val_next = mem_wdata;
                end
              end
            end
            OP_PUSH_BACK: begin
              if (!is_full) begin
                ok            = 1'b1;
                mem_we        = 1'b1;
                mem_waddr     = back_idx;
                back_idx_next = step_up(back_idx, cap);
                count_next    = count + 1'b1;
                rear_val_next = mem_wdata;
                if (is_empty) begin
                  front_val_next = mem_wdata;
                end
              end
            end
            OP_POP_FRONT: begin
              if (!is_empty) begin
                ok             = 1'b1;
                front_idx_next = step_up(front_idx, cap);
                count_next     = count - 1'b1;
                mem_raddr      = front_idx_next;
                pop_front_next = 1'b1;
              end
            end
            default: begin
              if (!is_empty) begin
                ok             = 1'b1;
                back_idx_next  = back_dn;
                count_next     = count - 1'b1;
                mem_raddr      = step_down(back_dn, cap);
                pop_front_next = 1'b0;
              end
            end
          endcase
          // a pop that leaves entries behind fetches the new end slot first
          if (ok && (req.op inside {OP_POP_FRONT, OP_POP_BACK})
              && count_next != '0) begin
            mem_re     = 1'b1;
            res_valid  = 1'b0;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        ok         = 1'b1;
        res_valid  = 1'b1;
        state_next = ST_IDLE;
        if (pop_front) begin
          front_val_next = mem_rdata;
        end else begin
          rear_val_next = mem_rdata;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res.accepted    = ok;
    res.front_value = (count_next == '0) ? '1 : sext(front_val_next);
    res.rear_value  = (count_next == '0) ? '1 : sext(rear_val_next);
    res.empty_flag  = (count_next == '0);
    res.full_flag   = (count_next == cap_next);
    res.entry_count = count_next[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cap       <= CAP_MAX;
      front_idx <= '0;
      back_idx  <= '0;
      count     <= '0;
      pop_front <= 1'b0;
    end else begin
      state     <= state_next;
      cap       <= cap_next;
      front_idx <= front_idx_next;
      back_idx  <= back_idx_next;
      count     <= count_next;
      pop_front <= pop_front_next;
    end
  end

  // end-value caches: only meaningful while count is non-zero
  always_ff @(posedge clk) begin
    front_val <= front_val_next;
    rear_val  <= rear_val_next;
  end

endmodule

[tb/tb_top.sv]
module tb_top;
  import cdq_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int QUIET_LIMIT = 3000;  // cycles without any handshake before giving up
  localparam int LONG_HOLD   = 120;   // receiver back-pressure stretch, in cycles

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  cdq_req_t         req       = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  cdq_rsp_t         rsp;
  logic             cfg_write = 1'b0;
  logic [CNT_W-1:0] cfg_data  = '0;

  // Items still to be offered, and the answers predicted for items already taken
  cdq_req_t ops_to_send[$];
  cdq_rsp_t deque_answers_q[$];

  // Shadow copy of the deque
  logic signed [VAL_W-1:0] shadow_slots [DEPTH];
  int unsigned             shadow_head;
  int unsigned             shadow_tail;   // one past the rear entry
  int unsigned             shadow_count;
  int unsigned             shadow_cap;

  // Idling control shared between stimulus, driver and receiver
  int unsigned idle_pct     = 0;
  bit          calm         = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned send_gap     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  circular_deque_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  // Ring index arithmetic: wrap by comparing with the active capacity
  function automatic int unsigned ring_next(int unsigned i);
    return (i + 1 >= shadow_cap) ? 0 : i + 1;
  endfunction

  function automatic int unsigned ring_prev(int unsigned i);
    return (i == 0) ? shadow_cap - 1 : i - 1;
  endfunction

  // Zero is taken as one slot, anything past the store saturates; always empties
  function automatic void set_capacity(logic [CNT_W-1:0] v);
    if (v == 0) begin
      shadow_cap = 1;
    end else if (v > DEPTH) begin
      shadow_cap = DEPTH;
    end else begin
      shadow_cap = 32'(v);
    end
    shadow_head  = 0;
    shadow_tail  = 0;
    shadow_count = 0;
  endfunction

  // Applies one operation to the shadow deque and returns the answer it should give
  function automatic cdq_rsp_t apply_deque_op(cdq_req_t r);
    cdq_rsp_t    a;
    logic        ok;
    int unsigned rear_at;
    ok = 1'b0;
    case (r.op)
      OP_PUSH_FRONT: begin
        if (shadow_count < shadow_cap) begin
          shadow_head                           = ring_prev(shadow_head);
          shadow_slots[shadow_head[SLOT_W-1:0]] = r.push_value;
          shadow_count++;
          ok = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count < shadow_cap) begin
          shadow_slots[shadow_tail[SLOT_W-1:0]] = r.push_value;
          shadow_tail                           = ring_next(shadow_tail);
          shadow_count++;
          ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_count != 0) begin
          shadow_head = ring_next(shadow_head);
          shadow_count--;
          ok = 1'b1;
        end
      end
      default: begin
        if (shadow_count != 0) begin
          shadow_tail = ring_prev(shadow_tail);
          shadow_count--;
          ok = 1'b1;
        end
      end
    endcase
    a.accepted = ok;
    if (shadow_count == 0) begin
      // empty deque reports all ones at both ends
      a.front_value = '1;
      a.rear_value  = '1;
    end else begin
      rear_at       = ring_prev(shadow_tail);
      a.front_value = shadow_slots[shadow_head[SLOT_W-1:0]];
      a.rear_value  = shadow_slots[rear_at[SLOT_W-1:0]];
    end
    a.empty_flag  = (shadow_count == 0);
    a.full_flag   = (shadow_count == shadow_cap);
    a.entry_count = shadow_count[CNT_W-1:0];
    return a;
  endfunction

  // Push values lean on the extremes now and then
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return {1'b0, {(VAL_W-1){1'b1}}};
      1:       return {1'b1, {(VAL_W-1){1'b0}}};
      2:       return '1;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic void queue_op(logic [1:0] op, logic signed [VAL_W-1:0] v);
    cdq_req_t r;
    r.op         = op;
    r.push_value = v;
    ops_to_send.push_back(r);
  endfunction

  // Alternating runs biased to fill or to drain, so that both full and empty get hit
  function automatic void random_mix(int unsigned n, int unsigned span);
    int unsigned left;
    bit          filling;
    left    = 0;
    filling = 1'b1;
    for (int unsigned k = 0; k < n; k++) begin
      if (left == 0) begin
        filling = 1'($urandom_range(1));
        left    = $urandom_range(span, 1);
      end
      left--;
      if ($urandom_range(99) < (filling ? 80 : 20)) begin
        queue_op($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
      end else begin
        queue_op($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, pick_value());
      end
    end
  endfunction

  // Wait until every item has gone in and every answer has come back
  task automatic settle();
    while (ops_to_send.size() != 0 || req_valid || deque_answers_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CNT_W-1:0] v);
    cfg_data  <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Request driver: valid only changes once the current item has gone in
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap  <= 0;
    end else if (!req_valid || !req_stall) begin
      if (send_gap > 0) begin
        send_gap  <= send_gap - 1;
        req_valid <= 1'b0;
      end else if (ops_to_send.size() != 0 && !calm && $urandom_range(99) < idle_pct) begin
        // insert a random idle gap before the next item
        send_gap  <= $urandom_range(13, 0);
        req_valid <= 1'b0;
      end else if (ops_to_send.size() != 0) begin
        req_valid <= 1'b1;
        req       <= ops_to_send.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response receiver: random stall bursts, plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_stall <= 1'b1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left <= LONG_HOLD;
      rsp_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall  <= 1'b1;
    end else if (!calm && $urandom_range(99) < idle_pct) begin
      stall_left <= $urandom_range(13, 0);
      rsp_stall  <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Scoreboard: predict on request handshake, check on response handshake
  always @(posedge clk) begin : scoreboard
    cdq_rsp_t want;
    if (rst) begin
      shadow_cap   = DEPTH;
      shadow_head  = 0;
      shadow_tail  = 0;
      shadow_count = 0;
    end else begin
      if (cfg_write)
        set_capacity(cfg_data);
      if (req_valid && !req_stall)
        deque_answers_q.push_back(apply_deque_op(req));
      if (rsp_valid && !rsp_stall) begin
        if (deque_answers_q.size() == 0) begin
          $error("response item with no request outstanding");
          fail_count++;
        end else begin
          want = deque_answers_q.pop_front();
          if (rsp.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, rsp.accepted);
            fail_count++;
          end
          if (rsp.front_value !== want.front_value) begin
            $error("front_value: expected %0d, got %0d", want.front_value, rsp.front_value);
            fail_count++;
          end
          if (rsp.rear_value !== want.rear_value) begin
            $error("rear_value: expected %0d, got %0d", want.rear_value, rsp.rear_value);
            fail_count++;
          end
          if (rsp.empty_flag !== want.empty_flag) begin
            $error("empty_flag: expected %0d, got %0d", want.empty_flag, rsp.empty_flag);
            fail_count++;
          end
          if (rsp.full_flag !== want.full_flag) begin
            $error("full_flag: expected %0d, got %0d", want.full_flag, rsp.full_flag);
            fail_count++;
          end
          if (rsp.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, rsp.entry_count);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: any handshake or register write counts as progress
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[circular_deque_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  int unsigned phase_caps [8] = '{2, 3, 7, 16, 1, 1023, 1536, 40};
  int unsigned idle_mix   [3] = '{0, 15, 40};

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset capacity: refused pops on empty, extreme values at both ends,
    // push front from slot zero wraps to the top of the store
    queue_op(OP_POP_FRONT,  32'sd5);
    queue_op(OP_POP_BACK,   32'sd6);
    queue_op(OP_PUSH_FRONT, 32'sh7fffffff);
    queue_op(OP_PUSH_BACK,  32'sh80000000);
    queue_op(OP_PUSH_FRONT, -32'sd1);
    queue_op(OP_PUSH_BACK,  32'sd0);
    queue_op(OP_POP_BACK,   32'sd0);
    queue_op(OP_POP_FRONT,  32'sd0);
    queue_op(OP_POP_FRONT,  32'sd0);
    queue_op(OP_POP_BACK,   32'sd0);
    queue_op(OP_POP_BACK,   32'sd0);
    queue_op(OP_PUSH_BACK,  32'sd1);
    queue_op(OP_PUSH_FRONT, 32'sd2);
    queue_op(OP_POP_FRONT,  32'sd0);
    queue_op(OP_POP_FRONT,  32'sd0);
    settle();

    // Capacity written as zero behaves as one slot: full after a single push
    write_capacity(CNT_W'(0));
    queue_op(OP_PUSH_BACK,  32'sd10);
    queue_op(OP_PUSH_BACK,  32'sd11);
    queue_op(OP_PUSH_FRONT, 32'sd12);
    queue_op(OP_POP_FRONT,  32'sd0);
    queue_op(OP_POP_BACK,   32'sd0);
    queue_op(OP_PUSH_FRONT, 32'sd13);
    queue_op(OP_POP_BACK,   32'sd0);
    settle();

    // All-ones write saturates to the full store; deep fill from both ends, then churn
    idle_pct = idle_mix[1];
    write_capacity('1);
    repeat (250)
      queue_op($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
    random_mix(40, 40);
    settle();

    foreach (phase_caps[p]) begin
      idle_pct = idle_mix[2'(p % 3)];
      write_capacity(CNT_W'(phase_caps[p]));
      // receiver holds off long enough for the block to back up its input
      if (phase_caps[p] == 16)
        hold_request = 1'b1;
      random_mix(40, (2 * phase_caps[p] + 2 > 80) ? 80 : 2 * phase_caps[p] + 2);
      settle();
    end

    // Closing stretch at full rate on both sides
    calm     = 1'b1;
    idle_pct = 0;
    write_capacity(CNT_W'(5));
    random_mix(30, 12);
    settle();
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("[circular_deque_unit] OK");
    end else begin
      $display("[circular_deque_unit] ERROR");
    end
    $finish;
  end

endmodule

[circular_deque_unit.f]
src/cdq_pkg.sv
src/cdq_ring_mem.sv
src/cdq_ctrl.sv
src/circular_deque_unit.sv
tb/tb_top.sv
